// ===== rtl/core/murhb_pkg.sv =====
`timescale 1ns / 1ps
package murhb_pkg;

   localparam int HASH_W     = 32;
   localparam int LEN_W      = 16;
   localparam int NBYTES_W   = 3;
   localparam int COUNT_W    = 16;
   localparam int BUCKET_W   = 17;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [HASH_W-1:0] MIX_MUL     = 32'h5bd1_e995;
   localparam int                MIX_SHIFT   = 24;
   localparam int                FIN_SHIFT_A = 13;
   localparam int                FIN_SHIFT_B = 15;

   // register index = paddr[3:2]
   localparam logic [1:0] CSR_HASH_SEED     = 2'd0;
   localparam logic [1:0] CSR_SERVER_COUNT  = 2'd1;
   localparam logic [1:0] CSR_BUCKET_OFFSET = 2'd2;

   localparam logic [HASH_W-1:0]  SEED_RESET   = 32'd7;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 16'd1;
   localparam logic [COUNT_W-1:0] OFFSET_RESET = 16'd0;

   typedef struct packed {
      logic [HASH_W-1:0]   key_word;
      logic [NBYTES_W-1:0] valid_bytes;
      logic                first_word;
      logic                last_word;
      logic [LEN_W-1:0]    key_length;
   } req_type;

   typedef struct packed {
      logic [HASH_W-1:0]   hash_value;
      logic [BUCKET_W-1:0] bucket;
      logic                bad_count;
   } rsp_type;

   typedef struct packed {
      logic [HASH_W-1:0]  hash_seed;
      logic [COUNT_W-1:0] server_count;
      logic [COUNT_W-1:0] bucket_offset;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // low bytes kept by a short tail word
   function automatic logic [HASH_W-1:0] tail_mask(input logic [NBYTES_W-1:0] nbytes);
      logic [HASH_W-1:0] mask;
      case (nbytes)
         3'd1: mask = 32'h0000_00ff;
         3'd2: mask = 32'h0000_ffff;
         3'd3: mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
      return mask;
   endfunction

endpackage

// ===== rtl/core/murhb_front.sv =====
`timescale 1ns / 1ps
module murhb_front import murhb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   input  cfg_type           cfg,
   input  q_status_type      q_stat,
   output logic              q_push,
   output logic [HASH_W-1:0] q_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KMUL,
      ST_KMIX,
      ST_HMIX,
      ST_TAIL,
      ST_PUSH
   } state_type;

   state_type           state_ff;
   logic [HASH_W-1:0]   h_ff;
   logic [HASH_W-1:0]   k_ff;
   logic [NBYTES_W-1:0] nb_ff;
   logic                last_ff;

   logic [HASH_W-1:0]   mul_a;
   logic [HASH_W-1:0]   product;
   logic [HASH_W-1:0]   h_start;
   logic                accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign q_push    = (state_ff == ST_PUSH) && !q_stat.full;
   assign q_data    = h_ff;

   assign h_start = req_data.first_word ?
                    (cfg.hash_seed ^ {{(HASH_W-LEN_W){1'b0}}, req_data.key_length}) : h_ff;

   // one shared constant multiplier
   always_comb begin
      case (state_ff)
         ST_KMUL: mul_a = k_ff;
         ST_KMIX: mul_a = k_ff ^ (k_ff >> MIX_SHIFT);
         ST_HMIX: mul_a = h_ff;
         ST_TAIL: mul_a = h_ff ^ (k_ff & tail_mask(nb_ff));
         default: mul_a = h_ff;
      endcase
   end

   assign product = mul_a * MIX_MUL;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         h_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  h_ff    <= h_start;
                  k_ff    <= req_data.key_word;
                  nb_ff   <= req_data.valid_bytes;
                  last_ff <= req_data.last_word;
                  if (req_data.valid_bytes >= 3'd4)
                     state_ff <= ST_KMUL;
                  else if (req_data.valid_bytes != 3'd0)
                     state_ff <= ST_TAIL;
                  else if (req_data.last_word)
                     state_ff <= ST_PUSH;
               end
            end
            ST_KMUL: begin
               k_ff     <= product;
               state_ff <= ST_KMIX;
            end
            ST_KMIX: begin
               k_ff     <= product;
               state_ff <= ST_HMIX;
            end
            ST_HMIX: begin
               h_ff     <= product ^ k_ff;
               state_ff <= last_ff ? ST_PUSH : ST_IDLE;
            end
            ST_TAIL: begin
               h_ff     <= product;
               state_ff <= last_ff ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH: begin
               if (!q_stat.full)
                  state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/murhb_fifo.sv =====
`timescale 1ns / 1ps
module murhb_fifo import murhb_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [HASH_W-1:0] push_data,
   input  logic              pop,
   output logic [HASH_W-1:0] pop_data,
   output q_status_type      stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [HASH_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff;
   logic [AW-1:0]     rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

endmodule

// ===== rtl/core/murhb_bucket.sv =====
`timescale 1ns / 1ps
module murhb_bucket import murhb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  q_status_type      q_stat,
   input  logic [HASH_W-1:0] q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data
);

   localparam int CNT_W = $clog2(HASH_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FMUL,
      ST_FXOR,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [HASH_W-1:0]  h_ff;
   logic [HASH_W-1:0]  dvd_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [HASH_W-1:0]  h_fxor;
   logic [COUNT_W:0]   shifted;
   logic [COUNT_W:0]   divisor;
   logic [COUNT_W-1:0] rem_next;
   logic               bad;
   logic               rsp_load;

   assign q_pop     = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bad      = (cfg.server_count == '0);
   assign h_fxor   = h_ff ^ (h_ff >> FIN_SHIFT_B);
   assign divisor  = {1'b0, cfg.server_count};
   assign shifted  = {rem_ff, dvd_ff[HASH_W-1]};
   // output register free or draining this cycle
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // restoring remainder step, one dividend bit a cycle
   always_comb begin
      if (shifted >= divisor)
         rem_next = COUNT_W'(shifted - divisor);
      else
         rem_next = shifted[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  h_ff     <= q_data ^ (q_data >> FIN_SHIFT_A);
                  state_ff <= ST_FMUL;
               end
            end
            ST_FMUL: begin
               h_ff     <= h_ff * MIX_MUL;
               state_ff <= ST_FXOR;
            end
            ST_FXOR: begin
               h_ff     <= h_fxor;
               dvd_ff   <= h_fxor;
               rem_ff   <= '0;
               cnt_ff   <= '1;
               state_ff <= bad ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
               rem_ff   <= rem_next;
               dvd_ff   <= dvd_ff << 1;
               cnt_ff   <= cnt_ff - 1'b1;
               if (cnt_ff == '0)
                  state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_data_ff.hash_value <= h_ff;
                  rsp_data_ff.bucket     <= bad ? '0 :
                                            ({1'b0, rem_ff} + {1'b0, cfg.bucket_offset});
                  rsp_data_ff.bad_count  <= bad;
                  state_ff               <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/murmur2_hash_bucket_core.sv =====
`timescale 1ns / 1ps
// channel   ports                              moves
// --------  ---------------------------------  ------------------------------------
// request   req_valid / req_stall / req_data   one key word per transaction
// response  rsp_valid / rsp_stall / rsp_data   hash, bucket, bad_count per key
// config    psel penable pwrite paddr pwdata   seed, server count, bucket offset
//
// a full word takes accept plus three passes of its one multiplier in the front end,
// a tail word accept and one pass, an empty word accept alone; a last word adds a
// step to hand the hash to the queue
// the back end finalizes each key (xor-shift, multiply, xor-shift) and runs a 32-step
// restoring divider for the modulo, skipping the divider when the server count is zero
// synchronous active-high reset; registers return to seed 7, count 1, offset 0
// req_stall is high while a word is mixing or a finished hash waits to enter the queue;
// a stalled response holds in the output register while the back end works ahead
module murmur2_hash_bucket_core import murhb_pkg::*; #(
   parameter int FIFO_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration registers
   logic [HASH_W-1:0]  hash_seed_ff;
   logic [COUNT_W-1:0] server_count_ff;
   logic [COUNT_W-1:0] bucket_offset_ff;
   logic [1:0]         csr_index;
   logic               csr_write;
   cfg_type            cfg;

   // queue between front and back end
   q_status_type       q_stat;
   logic               q_push;
   logic               q_pop;
   logic [HASH_W-1:0]  q_push_data;
   logic [HASH_W-1:0]  q_pop_data;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff     <= SEED_RESET;
         server_count_ff  <= COUNT_RESET;
         bucket_offset_ff <= OFFSET_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HASH_SEED:     hash_seed_ff     <= pwdata;
            CSR_SERVER_COUNT:  server_count_ff  <= pwdata[COUNT_W-1:0];
            CSR_BUCKET_OFFSET: bucket_offset_ff <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback, unmapped index reads zero
   always_comb begin
      case (csr_index)
         CSR_HASH_SEED:     prdata = hash_seed_ff;
         CSR_SERVER_COUNT:  prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, server_count_ff};
         CSR_BUCKET_OFFSET: prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, bucket_offset_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.hash_seed     = hash_seed_ff;
   assign cfg.server_count  = server_count_ff;
   assign cfg.bucket_offset = bucket_offset_ff;

   // front end: seeds and mixes each word into the running hash
   murhb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // unfinalized hashes of completed keys
   murhb_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   // back end: finalize, modulo, offset, response register
   murhb_bucket u_bucket (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_stat    (q_stat),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/murhb_hash_checker.sv =====
`timescale 1ns / 1ps
module murhb_hash_checker import murhb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending,
   output int                    keys_done,
   output int                    bad_keys
);

   logic [HASH_W-1:0]  seed_q;
   logic [COUNT_W-1:0] count_q;
   logic [COUNT_W-1:0] offset_q;
   logic [HASH_W-1:0]  run_hash;
   rsp_type            hash_queue[$];

   // mixes one key word into the running hash, returns 1 when a key completes
   function automatic bit absorb_word(input req_type w, output rsp_type r);
      logic [HASH_W-1:0] k;
      logic [HASH_W-1:0] fin;
      logic [HASH_W-1:0] rem;
      r = '0;
      if (w.first_word) run_hash = seed_q ^ {16'd0, w.key_length};
      if (w.valid_bytes >= 3'd4) begin
         k = w.key_word * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         run_hash = (run_hash * MIX_MUL) ^ k;
      end else if (w.valid_bytes != 3'd0) begin
         run_hash = (run_hash ^ (w.key_word & ((32'd1 << (8 * w.valid_bytes)) - 32'd1)))
                    * MIX_MUL;
      end
      if (!w.last_word) return 1'b0;
      fin = run_hash ^ (run_hash >> FIN_SHIFT_A);
      fin = fin * MIX_MUL;
      fin = fin ^ (fin >> FIN_SHIFT_B);
      r.hash_value = fin;
      if (count_q == '0) begin
         r.bad_count = 1'b1;
      end else begin
         rem = (fin % {16'd0, count_q}) + {16'd0, offset_q};
         r.bucket = rem[BUCKET_W-1:0];
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      rsp_type new_rsp;
      if (reset) begin
         seed_q   = SEED_RESET;
         count_q  = COUNT_RESET;
         offset_q = OFFSET_RESET;
         run_hash = '0;
         hash_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               CSR_HASH_SEED:     seed_q   = pwdata[HASH_W-1:0];
               CSR_SERVER_COUNT:  count_q  = pwdata[COUNT_W-1:0];
               CSR_BUCKET_OFFSET: offset_q = pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (hash_queue.size() == 0) begin
               $error("unexpected result: hash_value %h bucket %h bad_count %b",
                      rsp_data.hash_value, rsp_data.bucket, rsp_data.bad_count);
               fail_count++;
            end else begin
               exp_rsp = hash_queue.pop_front();
               keys_done++;
               if (exp_rsp.bad_count) bad_keys++;
               if (rsp_data.hash_value !== exp_rsp.hash_value) begin
                  $error("hash_value mismatch: expected %h, got %h",
                         exp_rsp.hash_value, rsp_data.hash_value);
                  fail_count++;
               end
               if (rsp_data.bucket !== exp_rsp.bucket) begin
                  $error("bucket mismatch: expected %h, got %h",
                         exp_rsp.bucket, rsp_data.bucket);
                  fail_count++;
               end
               if (rsp_data.bad_count !== exp_rsp.bad_count) begin
                  $error("bad_count mismatch: expected %b, got %b",
                         exp_rsp.bad_count, rsp_data.bad_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (absorb_word(req_data, new_rsp)) hash_queue.push_back(new_rsp);
         end
      end
      pending = hash_queue.size();
   end

endmodule

// ===== test/tb_murmur2_hash_bucket_core.sv =====
`timescale 1ns / 1ps
module tb_murmur2_hash_bucket_core;
   import murhb_pkg::*;

   // settling margin covers the back end finalizing and dividing a key, plus front end mixing
   localparam int SETTLE_CYCLES  = 60;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_WORDS    = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int keys_done;
   int bad_keys;

   int words_sent = 0;
   int config_phases = 0;
   int quiet_cycles = 0;
   // steady: both sides stop idling; long_hold_req: receiver backs off for a long stretch
   bit steady = 1'b0;
   bit long_hold_req = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   murmur2_hash_bucket_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // predicts every hash and bucket, compares each response transaction
   murhb_hash_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending),
      .keys_done  (keys_done),
      .bad_keys   (bad_keys)
   );

   // idle cycles before the next transaction, zero in steady stretches
   function automatic int idle_draw();
      if (steady) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic req_type key_item(input logic [HASH_W-1:0] word,
                                        input logic [NBYTES_W-1:0] nbytes,
                                        input logic is_first, input logic is_last,
                                        input logic [LEN_W-1:0] len);
      req_type w;
      w.key_word    = word;
      w.valid_bytes = nbytes;
      w.first_word  = is_first;
      w.last_word   = is_last;
      w.key_length  = len;
      return w;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   // with req_valid still high, so the next call can follow without a gap
   task automatic push_word(input req_type w);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // well-formed key of nbytes bytes; len_field normally equals nbytes
   task automatic send_key(input int nbytes, input logic [LEN_W-1:0] len_field,
                           input bit odd_full);
      int nwords;
      int vb;
      nwords = (nbytes + 3) / 4;
      if (nwords == 0) nwords = 1;
      for (int i = 0; i < nwords; i++) begin
         vb = (i < nwords - 1) ? 4 : nbytes - 4 * (nwords - 1);
         // byte counts above four still mean a full word
         if (vb == 4 && odd_full && $urandom_range(0, 1) == 1) vb = $urandom_range(5, 7);
         push_word(key_item($urandom, vb[NBYTES_W-1:0], i == 0, i == nwords - 1,
                            len_field));
      end
   endtask

   // pause the sender until every hash is out and the back end is quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // setup cycle, then access cycle; ends at the falling edge after release
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [HASH_W-1:0] seed, input logic [COUNT_W-1:0] count,
                             input logic [COUNT_W-1:0] offset);
      drain();
      csr_write(CSR_HASH_SEED, seed);
      csr_write(CSR_SERVER_COUNT, {16'd0, count});
      csr_write(CSR_BUCKET_OFFSET, {16'd0, offset});
      config_phases++;
   endtask

   // mostly well-formed keys with random content, plus noise and broken keys
   task automatic random_phase(input int nwords);
      int stop_at;
      int pick;
      int len;
      int n;
      bit drop_first;
      logic [LEN_W-1:0] len_field;
      stop_at = words_sent + nwords;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
            // now and then the length field disagrees with the bytes sent
            len_field = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom) : LEN_W'(len);
            send_key(len, len_field, $urandom_range(0, 7) == 0);
         end else if (pick < 90) begin
            // fully random word, any flag combination
            push_word(key_item($urandom, NBYTES_W'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               LEN_W'($urandom_range(0, 65535))));
         end else begin
            // broken key: either never closed or never opened
            n = $urandom_range(1, 3);
            drop_first = 1'($urandom_range(0, 1));
            for (int i = 0; i < n; i++)
               push_word(key_item($urandom, 3'd4, !drop_first && i == 0,
                                  drop_first && i == n - 1,
                                  LEN_W'($urandom_range(0, 65535))));
         end
      end
      steady = 1'b0;
   endtask

   // receiver: a fresh stall draw per response transaction
   initial begin : rsp_side
      int hold;
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = idle_draw();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_murmur2_hash_bucket_core NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: seed 7, one server, no offset
      // last word with no first word, mixing into the cleared hash
      push_word(key_item(32'h1234_5678, 3'd4, 1'b0, 1'b1, 16'd0));
      // empty key
      push_word(key_item(32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'd0));
      // all-ones word, length field far from the bytes sent
      push_word(key_item(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 16'hffff));
      push_word(key_item(32'h0000_0000, 3'd4, 1'b1, 1'b1, 16'd4));
      // one to three tail bytes
      push_word(key_item(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 16'd1));
      push_word(key_item(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 16'd2));
      push_word(key_item(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 16'd3));
      // byte counts above four act as full words
      push_word(key_item(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b1, 16'd4));
      push_word(key_item(32'h5a5a_5a5a, 3'd6, 1'b1, 1'b1, 16'd4));
      push_word(key_item(32'hdead_beef, 3'd7, 1'b1, 1'b1, 16'd4));
      // eleven-byte key over three words
      push_word(key_item(32'h6c6c_6568, 3'd4, 1'b1, 1'b0, 16'd11));
      push_word(key_item(32'h726f_776f, 3'd4, 1'b0, 1'b0, 16'd11));
      push_word(key_item(32'h0021_646c, 3'd3, 1'b0, 1'b1, 16'd11));
      // short word in the middle of a key, hashing continues after it
      push_word(key_item(32'hcafe_f00d, 3'd2, 1'b1, 1'b0, 16'd6));
      push_word(key_item(32'h0bad_cafe, 3'd4, 1'b0, 1'b1, 16'd6));
      // empty word in the middle of a key
      push_word(key_item(32'h0102_0304, 3'd4, 1'b1, 1'b0, 16'd8));
      push_word(key_item(32'hffff_0000, 3'd0, 1'b0, 1'b0, 16'd8));
      push_word(key_item(32'h0506_0708, 3'd4, 1'b0, 1'b1, 16'd8));
      // continues from the unfinalized hash of the previous key
      push_word(key_item(32'h00ab_cdef, 3'd3, 1'b0, 1'b1, 16'd0));

      // zero server count flags every result
      set_config(32'h0000_0000, 16'd0, 16'd0);
      push_word(key_item(32'h8000_0001, 3'd4, 1'b1, 1'b1, 16'd4));
      push_word(key_item(32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'd0));

      // every register at its maximum
      set_config(32'hffff_ffff, 16'hffff, 16'hffff);
      push_word(key_item(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 16'hffff));
      push_word(key_item(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 16'hffff));

      // random part, one register setting per phase
      set_config($urandom, COUNT_W'($urandom_range(1, 16)), COUNT_W'($urandom_range(0, 65535)));
      random_phase(PHASE_WORDS);

      // long back-pressure stretch: receiver holds off while keys keep coming
      drain();
      steady = 1'b1;
      long_hold_req = 1'b1;
      for (int i = 0; i < 40; i++) send_key($urandom_range(4, 12), 16'd8, 1'b0);
      steady = 1'b0;
      // sender waits until every hash is out, then resumes with the same settings
      drain();
      random_phase(PHASE_WORDS / 2);

      set_config(32'h0000_0000, 16'd0, COUNT_W'($urandom_range(0, 65535)));
      random_phase(PHASE_WORDS);

      set_config(32'hffff_ffff, 16'hffff, 16'hffff);
      random_phase(PHASE_WORDS);

      set_config($urandom, COUNT_W'($urandom_range(1, 65535)), 16'd0);
      random_phase(PHASE_WORDS);

      set_config($urandom, 16'd1, COUNT_W'($urandom_range(0, 65535)));
      random_phase(PHASE_WORDS / 2);

      drain();
      $display("sent %0d key words over %0d register settings, checked %0d hashes",
               words_sent, config_phases, keys_done);
      $display("%0d of those hashes ran with a zero server count", bad_keys);
      if (fail_count == 0)
         $display("tb_murmur2_hash_bucket_core OK");
      else
         $display("tb_murmur2_hash_bucket_core NOT OK");
      $finish;
   end

endmodule
